// ===== src/uniform_grid_spatial_hash_index_defines.svh =====
// Assertion macros used by the spatial hash index datapath.
`ifndef UNIFORM_GRID_SPATIAL_HASH_INDEX_DEFINES_SVH
`define UNIFORM_GRID_SPATIAL_HASH_INDEX_DEFINES_SVH
`ifndef ASSERT_OFF
`define UG_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("check failed");
`define UG_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("check failed");
`else
`define UG_ASSERT(lbl, clk, rst_n, prop)
`define UG_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== src/ugshi_pkg.sv =====
// Types and constants of the uniform grid spatial hash index.
package ugshi_pkg;

  typedef struct packed {
    logic               cmd;
    logic [30:0]        node_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] box_w;
    logic signed [31:0] box_h;
    logic [6:0]         max_out;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit_valid;
    logic [30:0] found_id;
    logic        last;
  } out_item_t;

  localparam logic       CMD_INSERT = 1'b0;
  localparam logic       CMD_QUERY  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_SIZE  = 2'd1;
  localparam logic [1:0] ST_POOL_FULL = 2'd2;

  localparam logic [30:0] DEF_CELL_SIZE = 31'd65536;
  localparam logic [6:0]  RES_MAX       = 7'd64;
  localparam logic [63:0] MASK_NEG_X    = 64'h5555_5555_5555_5555;
  localparam logic [63:0] MASK_NEG_Y    = 64'hAAAA_AAAA_AAAA_AAAA;
  localparam logic signed [35:0] GRID_LIM = 36'sd2147483647;

  // Divider runs one quotient bit per step; the bucket reduction four bits per step.
  localparam logic [5:0] DIV_LAST_STEP = 6'd33;
  localparam logic [5:0] MOD_LAST_STEP = 6'd15;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DIV_LOAD, S_DIV_RUN, S_DIV_STORE, S_CELL_INIT,
    S_HASH_MUL, S_HASH_ADD, S_HASH_MOD, S_HEAD_RD, S_HEAD_USE, S_CELL_NEXT,
    S_INS_OUT, S_BAD_OUT, S_Q_CHK, S_Q_RD, S_Q_OUT, S_Q_EMPTY
  } state_t;

  typedef struct packed {
    logic capture;
    logic grow;
    logic div_load;
    logic div_step;
    logic div_store;
    logic cell_init;
    logic hash_mul;
    logic hash_add;
    logic mod_step;
    logic head_rd;
    logic push;
    logic mark_full;
    logic cell_step;
    logic q_start;
    logic q_rd;
    logic q_emit;
    logic out_ins;
    logic out_bad;
    logic out_empty;
    logic clr_we;
  } ctl_t;

  typedef struct packed {
    logic is_query;
    logic bad_size;
    logic clr_last;
    logic div_last;
    logic div_all;
    logic mod_last;
    logic pool_full;
    logic y_end;
    logic x_end;
    logic q_none;
    logic q_last;
    logic out_free;
  } sts_t;

endpackage

// ===== src/ugshi_ram.sv =====
// Generic single write port RAM with registered read.
module ugshi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ===== src/ugshi_ctrl.sv =====
// Controller state machine of the spatial hash index.
module ugshi_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ugshi_pkg::sts_t sts,
  output ugshi_pkg::ctl_t ctl
);
  import ugshi_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:     if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:      if (in_valid) state_nxt = S_CHECK;
      S_CHECK:     state_nxt = (!sts.is_query && sts.bad_size) ? S_BAD_OUT : S_DIV_LOAD;
      S_DIV_LOAD:  state_nxt = S_DIV_RUN;
      S_DIV_RUN:   if (sts.div_last) state_nxt = S_DIV_STORE;
      S_DIV_STORE: state_nxt = sts.div_all ? S_CELL_INIT : S_DIV_LOAD;
      S_CELL_INIT: state_nxt = S_HASH_MUL;
      S_HASH_MUL:  state_nxt = S_HASH_ADD;
      S_HASH_ADD:  state_nxt = S_HASH_MOD;
      S_HASH_MOD:  if (sts.mod_last) state_nxt = S_HEAD_RD;
      S_HEAD_RD:   state_nxt = S_HEAD_USE;
      S_HEAD_USE:  state_nxt = sts.is_query ? S_Q_CHK : S_CELL_NEXT;
      S_CELL_NEXT: state_nxt = (sts.x_end && sts.y_end) ? S_INS_OUT : S_HASH_MUL;
      S_INS_OUT:   if (sts.out_free) state_nxt = S_IDLE;
      S_BAD_OUT:   if (sts.out_free) state_nxt = S_IDLE;
      S_Q_CHK:     state_nxt = sts.q_none ? S_Q_EMPTY : S_Q_RD;
      S_Q_RD:      state_nxt = S_Q_OUT;
      S_Q_OUT:     if (sts.out_free) state_nxt = sts.q_last ? S_IDLE : S_Q_RD;
      S_Q_EMPTY:   if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_CLEAR:     ctl.clr_we = 1'b1;
      S_IDLE:      ctl.capture = in_valid;
      S_CHECK:     ctl.grow = !sts.is_query && !sts.bad_size;
      S_DIV_LOAD:  ctl.div_load = 1'b1;
      S_DIV_RUN:   ctl.div_step = 1'b1;
      S_DIV_STORE: ctl.div_store = 1'b1;
      S_CELL_INIT: ctl.cell_init = 1'b1;
      S_HASH_MUL:  ctl.hash_mul = 1'b1;
      S_HASH_ADD:  ctl.hash_add = 1'b1;
      S_HASH_MOD:  ctl.mod_step = 1'b1;
      S_HEAD_RD:   ctl.head_rd = 1'b1;
      S_HEAD_USE: begin
        ctl.q_start   = sts.is_query;
        ctl.mark_full = !sts.is_query && sts.pool_full;
        ctl.push      = !sts.is_query && !sts.pool_full;
      end
      S_CELL_NEXT: ctl.cell_step = !(sts.x_end && sts.y_end);
      S_INS_OUT:   ctl.out_ins = sts.out_free;
      S_BAD_OUT:   ctl.out_bad = sts.out_free;
      S_Q_CHK:     ctl = '0;
      S_Q_RD:      ctl.q_rd = 1'b1;
      S_Q_OUT:     ctl.q_emit = sts.out_free;
      S_Q_EMPTY:   ctl.out_empty = sts.out_free;
      default:     ctl = '0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
endmodule

// ===== src/ugshi_dp.sv =====
// Datapath of the spatial hash index: divider, hash, bucket and entry stores, output register.
`include "uniform_grid_spatial_hash_index_defines.svh"
module ugshi_dp #(
  parameter int BUCKETS  = 64,
  parameter int ENTRIES  = 8192,
  parameter int MAX_SPAN = 100
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ugshi_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ugshi_pkg::out_item_t out_item,
  input  logic                 cfg_wr_en,
  input  logic [30:0]          cfg_wr_data,
  input  ugshi_pkg::ctl_t      ctl,
  output ugshi_pkg::sts_t      sts
);
  import ugshi_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int AW = $clog2(ENTRIES);
  localparam int LW = $clog2(ENTRIES + 1);
  localparam logic [BW:0]   BK_MOD  = (BW + 1)'(BUCKETS);
  localparam logic [LW-1:0] LINK_MAX = LW'(ENTRIES);
  localparam logic signed [33:0] SPAN_LIM = 34'(MAX_SPAN);

  in_item_t item_r;
  logic [30:0] cs_r;
  logic [5:0]  step_r;
  logic [1:0]  div_sel_r;
  logic [30:0] dv_rem_r;
  logic [33:0] dv_q_r;
  logic        dv_neg_r;
  logic signed [31:0] g_r [4];
  logic signed [31:0] gx_r, gy_r, gx1_r, gy1_r;
  logic [63:0] prod_r, p_r;
  logic [30:0] hb_r;
  logic        negx_r, negy_r;
  logic [BW-1:0] mod_r, clr_r;
  logic [LW-1:0] pool_r, link_r;
  logic [6:0]  n_r, lim_r;
  logic        full_r;
  out_item_t   out_r;
  logic        out_valid_r;

  logic [30:0] cs_eff;
  logic signed [33:0] dv_v;
  logic [33:0] dv_mag;
  logic [31:0] dv_trial;
  logic        dv_ge;
  logic [35:0] q_inc;
  logic signed [35:0] q_s;
  logic signed [31:0] g_sat;
  logic signed [31:0] cand;
  logic signed [33:0] span_x, span_y;
  logic        wide;
  logic [30:0] ha, hb;
  logic [31:0] hs, hs1, m1, m2;
  logic [63:0] prod, p_mix;
  logic [BW:0] mt;
  logic [BW-1:0] mod_nxt;
  logic [63:0] p_sh;
  logic [LW-1:0] head_rdata, ent_next;
  logic [LW+30:0] ent_rdata;
  logic [30:0] ent_node;
  logic [6:0]  lim_in;
  logic        out_free;
  logic        head_we;
  logic [BW-1:0] head_waddr;
  logic [LW-1:0] head_wdata;

  assign cs_eff = (cs_r == '0) ? 31'd1 : cs_r;

  always_comb begin
    case (div_sel_r)
      2'd0:    dv_v = 34'(item_r.pos_x);
      2'd1:    dv_v = 34'(item_r.pos_y);
      2'd2:    dv_v = 34'(item_r.pos_x) + 34'(item_r.box_w);
      default: dv_v = 34'(item_r.pos_y) + 34'(item_r.box_h);
    endcase
    dv_mag = dv_v[33] ? 34'(-dv_v) : 34'(dv_v);
  end

  assign dv_trial = {dv_rem_r, dv_q_r[33]};
  assign dv_ge    = dv_trial >= {1'b0, cs_eff};

  // Floor division: a negative value with a remainder rounds one cell further down.
  always_comb begin
    q_inc = {2'b00, dv_q_r} + {35'd0, (dv_rem_r != '0)};
    q_s   = dv_neg_r ? -$signed(q_inc) : $signed({2'b00, dv_q_r});
    if (q_s > GRID_LIM) begin
      g_sat = 32'sh7FFF_FFFF;
    end else if (q_s < -GRID_LIM) begin
      g_sat = -32'sh7FFF_FFFF;
    end else begin
      g_sat = 32'(q_s);
    end
  end

  assign cand   = (item_r.box_w > item_r.box_h) ? item_r.box_w : item_r.box_h;
  assign span_x = 34'(g_r[2]) - 34'(g_r[0]) + 34'sd1;
  assign span_y = 34'(g_r[3]) - 34'(g_r[1]) + 34'sd1;
  assign wide   = (span_x > SPAN_LIM) || (span_y > SPAN_LIM);

  // Cantor pairing, halving whichever factor is even so the product stays 32 by 32.
  always_comb begin
    ha   = gx_r[31] ? 31'(-gx_r) : gx_r[30:0];
    hb   = gy_r[31] ? 31'(-gy_r) : gy_r[30:0];
    hs   = {1'b0, ha} + {1'b0, hb};
    hs1  = hs + 32'd1;
    m1   = hs[0] ? hs : {1'b0, hs[31:1]};
    m2   = hs[0] ? {1'b0, hs1[31:1]} : hs1;
    prod = m1 * m2;
  end

  always_comb begin
    p_mix = prod_r + {33'd0, hb_r};
    if (negx_r) begin
      p_mix = p_mix ^ MASK_NEG_X;
    end
    if (negy_r) begin
      p_mix = p_mix ^ MASK_NEG_Y;
    end
  end

  always_comb begin
    mod_nxt = mod_r;
    p_sh    = p_r;
    for (int k = 0; k < 4; k++) begin
      mt = {mod_nxt, p_sh[63]};
      if (mt >= BK_MOD) begin
        mt = mt - BK_MOD;
      end
      mod_nxt = mt[BW-1:0];
      p_sh    = {p_sh[62:0], 1'b0};
    end
  end

  assign ent_node = ent_rdata[LW+30:LW];
  assign ent_next = ent_rdata[LW-1:0];
  assign lim_in   = (in_item.max_out > RES_MAX) ? RES_MAX : in_item.max_out;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r        <= DEF_CELL_SIZE;
      pool_r      <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cs_r <= cfg_wr_data;
      end else if (ctl.grow && ({1'b0, cs_r} < cand)) begin
        cs_r <= cand[30:0];
      end
      if (ctl.push) begin
        pool_r <= pool_r + 1'b1;
      end
      if (ctl.clr_we) begin
        clr_r <= clr_r + 1'b1;
      end
      if (ctl.out_ins || ctl.out_bad || ctl.out_empty || ctl.q_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r    <= in_item;
      lim_r     <= lim_in;
      div_sel_r <= '0;
      full_r    <= 1'b0;
    end
    if (ctl.div_load || ctl.hash_add) begin
      step_r <= '0;
    end else if (ctl.div_step || ctl.mod_step) begin
      step_r <= step_r + 1'b1;
    end
    if (ctl.div_load) begin
      dv_rem_r <= '0;
      dv_q_r   <= dv_mag;
      dv_neg_r <= dv_v[33];
    end else if (ctl.div_step) begin
      dv_rem_r <= dv_ge ? 31'(dv_trial - {1'b0, cs_eff}) : dv_trial[30:0];
      dv_q_r   <= {dv_q_r[32:0], dv_ge};
    end
    if (ctl.div_store) begin
      g_r[div_sel_r] <= g_sat;
      div_sel_r      <= div_sel_r + 1'b1;
    end
    if (ctl.cell_init) begin
      gx_r  <= g_r[0];
      gy_r  <= g_r[1];
      gx1_r <= wide ? g_r[0] : g_r[2];
      gy1_r <= wide ? g_r[1] : g_r[3];
    end else if (ctl.cell_step) begin
      if (gy_r == gy1_r) begin
        gx_r <= gx_r + 32'sd1;
        gy_r <= g_r[1];
      end else begin
        gy_r <= gy_r + 32'sd1;
      end
    end
    if (ctl.hash_mul) begin
      prod_r <= prod;
      hb_r   <= hb;
      negx_r <= gx_r[31];
      negy_r <= gy_r[31];
    end
    if (ctl.hash_add) begin
      p_r   <= p_mix;
      mod_r <= '0;
    end else if (ctl.mod_step) begin
      p_r   <= p_sh;
      mod_r <= mod_nxt;
    end
    if (ctl.mark_full) begin
      full_r <= 1'b1;
    end
    if (ctl.q_start) begin
      link_r <= head_rdata;
      n_r    <= '0;
    end else if (ctl.q_emit) begin
      link_r <= ent_next;
      n_r    <= n_r + 7'd1;
    end
    if (ctl.out_ins) begin
      out_r <= '{status: (full_r ? ST_POOL_FULL : ST_OK), hit_valid: 1'b0,
                 found_id: '0, last: 1'b1};
    end else if (ctl.out_bad) begin
      out_r <= '{status: ST_BAD_SIZE, hit_valid: 1'b0, found_id: '0, last: 1'b1};
    end else if (ctl.out_empty) begin
      out_r <= '{status: ST_OK, hit_valid: 1'b0, found_id: '0, last: 1'b1};
    end else if (ctl.q_emit) begin
      out_r <= '{status: ST_OK, hit_valid: 1'b1, found_id: ent_node, last: sts.q_last};
    end
  end

  // Bucket heads are zeroed by the clearing pass after reset.
  assign head_we    = ctl.clr_we || ctl.push;
  assign head_waddr = ctl.clr_we ? clr_r : mod_r;
  assign head_wdata = ctl.clr_we ? '0 : (pool_r + 1'b1);

  ugshi_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (ctl.head_rd),
    .raddr (mod_r),
    .rdata (head_rdata)
  );

  ugshi_ram #(.WIDTH(LW + 31), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (pool_r[AW-1:0]),
    .wdata ({item_r.node_id, head_rdata}),
    .re    (ctl.q_rd),
    .raddr (AW'(link_r - 1'b1)),
    .rdata (ent_rdata)
  );

  always_comb begin
    sts.is_query  = (item_r.cmd == CMD_QUERY);
    sts.bad_size  = item_r.box_w[31] || item_r.box_h[31];
    sts.clr_last  = (clr_r == BW'(BUCKETS - 1));
    sts.div_last  = (step_r == DIV_LAST_STEP);
    sts.div_all   = sts.is_query ? (div_sel_r == 2'd1) : (div_sel_r == 2'd3);
    sts.mod_last  = (step_r == MOD_LAST_STEP);
    sts.pool_full = (pool_r >= LINK_MAX);
    sts.y_end     = (gy_r == gy1_r);
    sts.x_end     = (gx_r == gx1_r);
    sts.q_none    = (link_r == '0) || (link_r > LINK_MAX) || (lim_r == '0);
    sts.q_last    = (ent_next == '0) || (ent_next > LINK_MAX) || ((n_r + 7'd1) >= lim_r);
    sts.out_free  = out_free;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `UG_ASSERT(a_pool_bound, clk, rst_n, pool_r <= LINK_MAX)
  `UG_ASSERT(a_push_counts, clk, rst_n, ctl.push |=> pool_r == $past(pool_r) + 1'b1)
  `UG_ASSERT(a_load_when_free, clk, rst_n, (ctl.out_ins || ctl.out_bad || ctl.out_empty || ctl.q_emit) |-> out_free)
endmodule

// ===== src/uniform_grid_spatial_hash_index.sv =====
// Uniform grid spatial hash index: one item at a time, one serial floor divider and one hash unit.
// Query: two floor divisions, hash, bucket read, then one result per bucket entry up to the
// limit; an empty bucket gives one empty result. Insert: four floor divisions, then a hash and
// a bucket update per covered cell, then its one result; a negative size skips them. Input
// stalls until the last result is loaded (a full output register adds its wait); the next
// transfer can follow in the cycle after. After reset the bucket heads are cleared first.
module uniform_grid_spatial_hash_index #(
  parameter int BUCKETS  = 64,
  parameter int ENTRIES  = 8192,
  parameter int MAX_SPAN = 100
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ugshi_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ugshi_pkg::out_item_t out_item,
  input  logic                 cfg_wr_en,
  input  logic [30:0]          cfg_wr_data
);
  import ugshi_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ugshi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  ugshi_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .MAX_SPAN(MAX_SPAN)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ctl         (ctl),
    .sts         (sts)
  );
endmodule

// ===== verif/tb_uniform_grid_spatial_hash_index.sv =====
// Self-checking testbench for the uniform grid spatial hash index, with a scoreboard class.
module tb_uniform_grid_spatial_hash_index;
  import ugshi_pkg::*;

  localparam int NUM_BUCKETS = 64;
  localparam int POOL_DEPTH  = 8192;
  localparam int SPAN_LIMIT  = 100;
  localparam int IDLE_LIMIT  = 50000;
  localparam int SETTLE_CYC  = 400;
  localparam int ITEM_BITS   = $bits(in_item_t);

  // Mirrors the grid index and keeps the results it must produce, oldest first.
  class grid_index_scoreboard;
    logic [30:0] pitch;
    int          bucket_link[NUM_BUCKETS];
    logic [30:0] slot_node[POOL_DEPTH];
    int          slot_link[POOL_DEPTH];
    int          slots_taken;
    out_item_t   pending_results[$];
    int          fails;

    function void load_pitch(logic [30:0] v);
      pitch = v;
    endfunction

    function void clear();
      load_pitch(DEF_CELL_SIZE);
      foreach (bucket_link[i]) bucket_link[i] = 0;
      slots_taken = 0;
      fails = 0;
    endfunction

    function longint floor_cell(longint v, longint cs);
      longint q;
      q = v / cs;
      if (v < 0 && q * cs != v) q--;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483647) q = -64'sd2147483647;
      return q;
    endfunction

    function int grid_bucket(longint gx, longint gy);
      longint unsigned a, b, s, p;
      a = (gx < 0) ? -gx : gx;
      b = (gy < 0) ? -gy : gy;
      s = a + b;
      p = (s[0] ? s * ((s + 1) >> 1) : (s >> 1) * (s + 1)) + b;
      if (gx < 0) p ^= MASK_NEG_X;
      if (gy < 0) p ^= MASK_NEG_Y;
      return int'(p % NUM_BUCKETS);
    endfunction

    function void add_result(logic [1:0] st, logic hv, logic [30:0] id, logic lst);
      out_item_t r;
      r.status = st;
      r.hit_valid = hv;
      r.found_id = id;
      r.last = lst;
      pending_results.push_back(r);
    endfunction

    function void note_input(in_item_t it);
      longint x, y, w, h, cs, cand, gx0, gy0, gx1, gy1;
      int     link, lim, n;
      bit     full;
      x = $signed(it.pos_x);
      y = $signed(it.pos_y);
      w = $signed(it.box_w);
      h = $signed(it.box_h);
      full = 0;
      if (it.cmd == CMD_INSERT) begin
        if (w < 0 || h < 0) begin
          add_result(ST_BAD_SIZE, 1'b0, '0, 1'b1);
          return;
        end
        cand = (w > h) ? w : h;
        if (cand > longint'(pitch)) pitch = 31'(cand & 64'h7FFF_FFFF);
        cs = (pitch != 0) ? longint'(pitch) : 1;
        gx0 = floor_cell(x, cs);
        gy0 = floor_cell(y, cs);
        gx1 = floor_cell(x + w, cs);
        gy1 = floor_cell(y + h, cs);
        // A box wider than the span limit lands only in its corner cell.
        if (gx1 - gx0 + 1 > SPAN_LIMIT || gy1 - gy0 + 1 > SPAN_LIMIT) begin
          gx1 = gx0;
          gy1 = gy0;
        end
        for (longint gx = gx0; gx <= gx1; gx++) begin
          for (longint gy = gy0; gy <= gy1; gy++) begin
            int bk;
            bk = grid_bucket(gx, gy);
            if (slots_taken >= POOL_DEPTH) begin
              full = 1;
            end else begin
              slot_node[slots_taken] = it.node_id;
              slot_link[slots_taken] = bucket_link[bk];
              bucket_link[bk] = slots_taken + 1;
              slots_taken++;
            end
          end
        end
        add_result(full ? ST_POOL_FULL : ST_OK, 1'b0, '0, 1'b1);
      end else begin
        lim = (it.max_out > RES_MAX) ? int'(RES_MAX) : int'(it.max_out);
        cs = (pitch != 0) ? longint'(pitch) : 1;
        link = bucket_link[grid_bucket(floor_cell(x, cs), floor_cell(y, cs))];
        n = 0;
        while (link != 0 && n < lim) begin
          add_result(ST_OK, 1'b1, slot_node[link - 1], 1'b0);
          n++;
          link = slot_link[link - 1];
        end
        if (n == 0) add_result(ST_OK, 1'b0, '0, 1'b1);
        else pending_results[$].last = 1'b1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d id %0d", got.status, got.found_id);
        fails++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        fails++;
      end
      if (got.hit_valid !== want.hit_valid) begin
        $error("hit_valid: expected %0d, got %0d", want.hit_valid, got.hit_valid);
        fails++;
      end
      if (got.found_id !== want.found_id) begin
        $error("found_id: expected %0d, got %0d", want.found_id, got.found_id);
        fails++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_wr_en;
  logic [30:0] cfg_wr_data;

  grid_index_scoreboard sb;
  int   gap_max;
  bit   hold_req;
  int   idle_cycles;
  int   inserted_x[$];
  int   inserted_y[$];

  uniform_grid_spatial_hash_index #(
    .BUCKETS(NUM_BUCKETS),
    .ENTRIES(POOL_DEPTH),
    .MAX_SPAN(SPAN_LIMIT)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item(out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Both transfers are observed here, along with the idle watchdog.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_item);
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("uniform_grid_spatial_hash_index regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: random stall before each transfer, plus one long hold-off on request.
  initial begin
    int g;
    out_stall <= 1'b1;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end
      g = $urandom_range(0, gap_max);
      if (g > 0) begin
        out_stall <= 1'b1;
        repeat (g) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  function automatic in_item_t make_item(logic cmd, logic [30:0] id, int x, int y,
                                         int w, int h, logic [6:0] mo);
    in_item_t it;
    it.cmd = cmd;
    it.node_id = id;
    it.pos_x = x;
    it.pos_y = y;
    it.box_w = w;
    it.box_h = h;
    it.max_out = mo;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int g;
    in_item <= it;
    in_valid <= 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    g = $urandom_range(0, gap_max);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_pitch(logic [30:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.load_pitch(v);
  endtask

  // Mostly inserts and queries around earlier boxes, with some fully random noise.
  task automatic random_traffic(int n);
    in_item_t    it;
    int          x, y, k;
    int unsigned cs;
    for (int i = 0; i < n; i++) begin
      cs = (sb.pitch > 1) ? sb.pitch : 2;
      if (cs > 32'h0100_0000) cs = 32'h0100_0000;
      if ($urandom_range(0, 9) == 0) begin
        it = ITEM_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      end else if ($urandom_range(0, 1) == 0 || inserted_x.size() == 0) begin
        x = $signed($urandom_range(0, 8 * cs)) - int'(4 * cs);
        y = $signed($urandom_range(0, 8 * cs)) - int'(4 * cs);
        inserted_x.push_back(x);
        inserted_y.push_back(y);
        it = make_item(CMD_INSERT, 31'($urandom), x, y, $urandom_range(0, cs),
                       $urandom_range(0, cs), 7'($urandom));
      end else begin
        k = $urandom_range(0, inserted_x.size() - 1);
        it = make_item(CMD_QUERY, 31'($urandom), inserted_x[k] + $urandom_range(0, 3),
                       inserted_y[k] + $urandom_range(0, 3), $urandom, $urandom,
                       7'($urandom_range(0, 127)));
      end
      send_item(it);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    gap_max = 16;
    hold_req = 0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, negative sizes, empty and capped queries, growth.
    send_item(make_item(CMD_INSERT, 31'h7FFF_FFFF, 0, 0, 0, 0, 7'd0));
    send_item(make_item(CMD_INSERT, 31'd0, -1, -1, 65536, 65536, 7'h7F));
    send_item(make_item(CMD_INSERT, 31'd5, 0, 0, -1, 0, 7'd1));
    send_item(make_item(CMD_INSERT, 31'd6, 0, 0, 0, 32'sh8000_0000, 7'd1));
    send_item(make_item(CMD_QUERY, 31'd0, 0, 0, 0, 0, 7'd64));
    send_item(make_item(CMD_QUERY, 31'd0, 0, 0, 0, 0, 7'd0));
    send_item(make_item(CMD_QUERY, 31'd0, -1, -1, -1, -1, 7'd127));
    send_item(make_item(CMD_QUERY, 31'd0, -1, -1, 0, 0, 7'd1));
    send_item(make_item(CMD_QUERY, 31'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 7'd64));
    send_item(make_item(CMD_INSERT, 31'd7, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 7'd0));
    send_item(make_item(CMD_QUERY, 31'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 7'd64));
    send_item(make_item(CMD_INSERT, 31'd8, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF, 5, 7'd0));
    send_item(make_item(CMD_QUERY, 31'd0, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 7'd127));
    send_item(make_item(CMD_QUERY, 31'd0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 7'd127));

    // A zero cell size acts as one, which saturates the most negative coordinates.
    write_pitch(31'd0);
    send_item(make_item(CMD_QUERY, 31'd0, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 7'd64));
    send_item(make_item(CMD_INSERT, 31'd9, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 7'd0));
    send_item(make_item(CMD_INSERT, 31'd10, -32'sd2147483647, 32'sh8000_0000, 0, 0, 7'd0));
    send_item(make_item(CMD_QUERY, 31'd0, 32'sh8000_0000, 32'sh8000_0000, 0, 0, 7'd64));
    send_item(make_item(CMD_QUERY, 31'd0, 7, -7, 0, 0, 7'd64));

    write_pitch(31'h7FFF_FFFF);
    send_item(make_item(CMD_QUERY, 31'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 0, 0, 7'd64));
    send_item(make_item(CMD_INSERT, 31'd11, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 7'd0));
    send_item(make_item(CMD_QUERY, 31'd0, -1, -1, 0, 0, 7'd64));

    // Random phases under several cell sizes; the second one includes the hold-off.
    write_pitch(31'd65536);
    random_traffic(24);
    write_pitch(31'd1);
    gap_max = 0;
    hold_req = 1;
    random_traffic(24);
    gap_max = 16;
    write_pitch(31'($urandom_range(2, 32'h7FFF_FFFF)));
    random_traffic(24);
    write_pitch(31'd4096);
    random_traffic(24);

    // Close with a four-cell box and queries on one of its cells and on an empty spot.
    write_pitch(31'd1);
    send_item(make_item(CMD_INSERT, 31'd12, 3, 3, 1, 1, 7'd0));
    send_item(make_item(CMD_QUERY, 31'd0, 3, 3, 0, 0, 7'd127));
    send_item(make_item(CMD_QUERY, 31'd0, 20, 20, 0, 0, 7'd64));

    drain();
    if (sb.fails == 0 && sb.pending_results.size() == 0) begin
      $display("uniform_grid_spatial_hash_index regression: pass");
    end else begin
      $display("uniform_grid_spatial_hash_index regression: fail");
    end
    $finish;
  end
endmodule
